// ----- sv/sat_pkg.sv -----
// Shared widths, codes and defaults for the sorted array table.
package sat_pkg;

   localparam int MODE_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 9;
   localparam int LIMIT_W  = 9;

   localparam int DEPTH_DEFAULT = 256;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd2;

endpackage

// ----- sv/sat_if.sv -----
// Request and response channel interfaces of the sorted array table.
interface sat_req_if;
   import sat_pkg::*;

   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [VALUE_W-1:0] value;
   logic [INDEX_W-1:0] index;

   modport source (output valid, output mode, output value, output index, input ready);
   modport sink   (input valid, input mode, input value, input index, output ready);
endinterface

interface sat_rsp_if;
   import sat_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [VALUE_W-1:0]  read_value;
   logic [COUNT_W-1:0]  count;

   modport source (output valid, output status, output read_value, output count, input ready);
   modport sink   (input valid, input status, input read_value, input count, output ready);
endinterface

// ----- sv/sat_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module sat_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- sv/sorted_array_table.sv -----
// Sorted table top level: keeps words in ascending unsigned order in one RAM.
// One request is handled at a time: a request is accepted only in the idle state, an
// insert moves up every entry greater than the new word, and a remove moves down every entry
// above the removed index. The response becomes valid in the same cycle that the next request
// can be accepted. The unused mode 3 is answered with status OK and leaves the table unchanged.
// Reset (synchronous, active high) empties the table and sets the limit to 256; RAM contents
// are not cleared since entries at or above the count are never read.
module sorted_array_table #(
   parameter int DEPTH = sat_pkg::DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   sat_req_if.sink                     req,
   sat_rsp_if.source                   rsp,
   input  logic                        csr_wr_en,
   input  logic [sat_pkg::LIMIT_W-1:0] csr_wr_data
);
   import sat_pkg::*;

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = ((CW > LIMIT_W) ? CW : LIMIT_W) + 1;

   typedef enum logic [2:0] {S_IDLE, S_SHIFT, S_PUT, S_RDWAIT, S_FIN} state_type;

   state_type            state_ff;
   logic [CW-1:0]        count_ff;
   logic [LIMIT_W-1:0]   limit_ff;
   logic [VALUE_W-1:0]   value_ff;
   logic                 is_ins_ff;
   logic [AW-1:0]        cur_ff;
   logic                 iss_ff;
   logic                 got_ff;
   logic [AW-1:0]        got_addr_ff;
   logic [STATUS_W-1:0]  res_status_ff;
   logic [VALUE_W-1:0]   res_value_ff;
   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [VALUE_W-1:0]   rsp_value_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;

   logic                 accept;
   logic                 full;
   logic                 idx_ok;
   logic                 idx_last;
   logic                 cur_last;
   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [VALUE_W-1:0]   ram_wr_data;
   logic                 ram_rd_en;
   logic [AW-1:0]        ram_rd_addr;
   logic [VALUE_W-1:0]   ram_rd_data;

   assign req.ready      = (state_ff == S_IDLE);
   assign accept         = req.valid && req.ready;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.read_value = rsp_value_ff;
   assign rsp.count      = rsp_count_ff;

   assign full     = (CMPW'(count_ff) >= CMPW'(limit_ff)) || (CMPW'(count_ff) >= CMPW'(DEPTH));
   assign idx_ok   = CMPW'(req.index) < CMPW'(count_ff);
   assign idx_last = (CMPW'(req.index) + CMPW'(1)) == CMPW'(count_ff);
   // Insert walks down to entry zero; remove walks up to the last old entry, which equals
   // the already decremented count.
   assign cur_last = is_ins_ff ? (cur_ff == '0) : (cur_ff == AW'(count_ff));

   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = cur_ff;
      if (state_ff == S_IDLE) begin
         ram_rd_addr = AW'(req.index);
         ram_rd_en   = accept && (req.mode == MODE_READ) && idx_ok;
      end else if (state_ff == S_SHIFT) begin
         ram_rd_en = iss_ff;
      end

      ram_wr_en   = 1'b0;
      ram_wr_addr = '0;
      ram_wr_data = value_ff;
      if (state_ff == S_SHIFT && got_ff) begin
         ram_wr_en = 1'b1;
         if (is_ins_ff) begin
            ram_wr_addr = got_addr_ff + AW'(1);
            if (value_ff < ram_rd_data) begin
               ram_wr_data = ram_rd_data;
            end
         end else begin
            ram_wr_addr = got_addr_ff - AW'(1);
            ram_wr_data = ram_rd_data;
         end
      end else if (state_ff == S_PUT) begin
         ram_wr_en = 1'b1;
      end
   end

   sat_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         iss_ff       <= 1'b0;
         got_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         // In S_FIN the response register is reloaded whenever it would be emptied.
         if (rsp_valid_ff && rsp.ready && state_ff != S_FIN) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  value_ff      <= req.value;
                  is_ins_ff     <= (req.mode == MODE_INSERT);
                  res_value_ff  <= '0;
                  got_ff        <= 1'b0;
                  case (req.mode)
                     MODE_INSERT: begin
                        if (full) begin
                           res_status_ff <= STATUS_FULL;
                           state_ff      <= S_FIN;
                        end else begin
                           res_status_ff <= STATUS_OK;
                           count_ff      <= count_ff + CW'(1);
                           if (count_ff == '0) begin
                              state_ff <= S_PUT;
                           end else begin
                              cur_ff   <= AW'(count_ff - CW'(1));
                              iss_ff   <= 1'b1;
                              state_ff <= S_SHIFT;
                           end
                        end
                     end
                     MODE_REMOVE: begin
                        if (!idx_ok) begin
                           res_status_ff <= STATUS_BAD_INDEX;
                           state_ff      <= S_FIN;
                        end else begin
                           res_status_ff <= STATUS_OK;
                           count_ff      <= count_ff - CW'(1);
                           if (idx_last) begin
                              state_ff <= S_FIN;
                           end else begin
                              cur_ff   <= AW'(req.index) + AW'(1);
                              iss_ff   <= 1'b1;
                              state_ff <= S_SHIFT;
                           end
                        end
                     end
                     MODE_READ: begin
                        if (!idx_ok) begin
                           res_status_ff <= STATUS_BAD_INDEX;
                           state_ff      <= S_FIN;
                        end else begin
                           res_status_ff <= STATUS_OK;
                           state_ff      <= S_RDWAIT;
                        end
                     end
                     default: begin
                        res_status_ff <= STATUS_OK;
                        state_ff      <= S_FIN;
                     end
                  endcase
               end
            end
            S_SHIFT: begin
               // Reads run one entry ahead of the write-back of the previous entry.
               got_ff      <= iss_ff;
               got_addr_ff <= cur_ff;
               if (iss_ff) begin
                  if (cur_last) begin
                     iss_ff <= 1'b0;
                  end else if (is_ins_ff) begin
                     cur_ff <= cur_ff - AW'(1);
                  end else begin
                     cur_ff <= cur_ff + AW'(1);
                  end
               end
               if (got_ff) begin
                  if (is_ins_ff) begin
                     if (!(value_ff < ram_rd_data)) begin
                        state_ff <= S_FIN;
                     end else if (got_addr_ff == '0) begin
                        state_ff <= S_PUT;
                     end
                  end else if (got_addr_ff == AW'(count_ff)) begin
                     state_ff <= S_FIN;
                  end
               end
            end
            S_PUT: begin
               state_ff <= S_FIN;
            end
            S_RDWAIT: begin
               res_value_ff <= ram_rd_data;
               state_ff     <= S_FIN;
            end
            S_FIN: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_value_ff  <= res_value_ff;
                  rsp_count_ff  <= COUNT_W'(count_ff);
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_write_below_count: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (CMPW'(ram_wr_addr) < CMPW'(count_ff)))
      else $error("table write beyond the current count");

   a_count_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("entry count changed without an accepted beat");

   a_shift_progress: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (iss_ff || got_ff))
      else $error("shift loop has no read in flight");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      accept && (req.mode == MODE_INSERT) && full |=> $stable(count_ff) && (state_ff == S_FIN))
      else $error("refused insert changed the table");

endmodule
